### design/wsfd_pkg.sv
// Package: shared constants, types and tables for the windowed-sinc FIR designer.
`timescale 1ns / 1ps
`default_nettype none
package wsfd_pkg;

  localparam int MaxTaps     = 64;
  localparam int AddrW       = $clog2(MaxTaps);
  localparam int OrderW      = 6;
  localparam int CutW        = 17;
  localparam int RawW        = 24;
  localparam int SumW        = 32;
  localparam int CoefW       = 18;
  localparam int CordicIters = 16;
  localparam int IterW       = 4;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [21:0]        PiQ20      = 22'd3294198;
  localparam logic signed [23:0] W54Q22     = 24'sd2264924;
  localparam logic signed [23:0] W46Q22     = 24'sd1929380;
  localparam logic signed [24:0] OneQ22     = 25'sd4194304;
  localparam logic signed [24:0] RawMax     = 25'sd8388607;
  localparam logic signed [24:0] RawMin     = -25'sd8388608;

  // configuration register indexes
  localparam logic [0:0] RegOrder  = 1'b0;
  localparam logic [0:0] RegCutoff = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_SETUP, ST_SC_CORDIC, ST_SC_DIV, ST_WN_DIV, ST_WN_CORDIC,
    ST_MUL, ST_STORE, ST_RD, ST_RDWAIT, ST_CDIV, ST_EMIT
  } wsfd_state_t;

  // divider request/status
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } wsfd_div_req_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] quo;
  } wsfd_div_sts_t;

  function automatic logic [31:0] atan_turn(input logic [IterW-1:0] k);
    case (k)
      4'd0:  atan_turn = 32'd536870912;
      4'd1:  atan_turn = 32'd316933406;
      4'd2:  atan_turn = 32'd167458907;
      4'd3:  atan_turn = 32'd85004756;
      4'd4:  atan_turn = 32'd42667331;
      4'd5:  atan_turn = 32'd21354465;
      4'd6:  atan_turn = 32'd10679838;
      4'd7:  atan_turn = 32'd5340245;
      4'd8:  atan_turn = 32'd2670163;
      4'd9:  atan_turn = 32'd1335087;
      4'd10: atan_turn = 32'd667544;
      4'd11: atan_turn = 32'd333772;
      4'd12: atan_turn = 32'd166886;
      4'd13: atan_turn = 32'd83443;
      4'd14: atan_turn = 32'd41722;
      default: atan_turn = 32'd20861;
    endcase
  endfunction

endpackage
`default_nettype wire

### design/wsfd_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module wsfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### design/wsfd_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wsfd_cordic (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] phase,
  output logic             busy,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);
  import wsfd_pkg::*;

  logic signed [33:0] x, y;
  logic signed [33:0] z;
  logic [IterW-1:0]   k;
  logic               flip;
  logic [31:0]        p_adj;
  logic               flip_in;

  // fold into the right half plane
  always_comb begin
    flip_in = (phase + 32'h4000_0000) >= 32'h8000_0000;
    p_adj   = flip_in ? phase + 32'h8000_0000 : phase;
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      k    <= '0;
      flip <= flip_in;
      x    <= CordicGain;
      y    <= '0;
      z    <= {{2{p_adj[31]}}, p_adj};
    end else if (busy) begin
      // >>> on signed floors toward minus infinity
      if (!z[33]) begin
        x <= x - (y >>> k);
        y <= y + (x >>> k);
        z <= z - $signed({2'b00, atan_turn(k)});
      end else begin
        x <= x + (y >>> k);
        y <= y - (x >>> k);
        z <= z + $signed({2'b00, atan_turn(k)});
      end
      k <= k + 1'b1;
      if (k == IterW'(CordicIters - 1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### design/wsfd_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wsfd_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire wsfd_pkg::wsfd_div_req_t req,
  output wsfd_pkg::wsfd_div_sts_t      sts
);
  import wsfd_pkg::*;

  logic [63:0] q;
  logic [47:0] d;
  logic [48:0] r;
  logic [6:0]  cnt;
  logic [48:0] trial;
  logic        busy;

  assign trial = {r[47:0], q[63]} - {1'b0, d};
  assign sts   = '{busy: busy, quo: q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      q    <= req.num;
      d    <= req.den;
      r    <= '0;
      cnt  <= '0;
    end else if (busy) begin
      if (!trial[48]) begin
        r <= trial;
        q <= {q[62:0], 1'b1};
      end else begin
        r <= {r[47:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == 7'd63) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### design/windowed_sinc_fir_designer_core.sv
// Top level of the windowed-sinc Hamming FIR designer.
// Usage: write filter_order (index 0) and cutoff_frac (index 1) on the cfg port
// while idle. A request on s_axis with tdata[0]=1 designs N+1 taps; tdata[0]=0
// is taken and dropped. Phase one computes each raw tap (CORDIC sine, divide,
// window divide, CORDIC cosine, multiply) into a 64x24 RAM while summing; phase
// two reads each tap back, divides by the sum and emits it on m_axis, with
// tlast on tap N. Each tap of phase one uses two CORDIC passes and two divides
// (one of each when the sinc phase is zero); each tap of phase two uses one
// divide and a RAM read. One request is handled at a time: s_axis_tready is
// low from acceptance until the last tap is loaded into the output register.
// A stalled receiver holds the output register and the sequencer waits. Reset
// (rst, synchronous) restores order 31 and cutoff 32768 and idles the block;
// the RAM needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module windowed_sinc_fir_designer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] start_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [5:0] tap_index, [23:6] coefficient
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);
  import wsfd_pkg::*;

  wsfd_state_t state, state_next;

  logic [OrderW-1:0] filter_order;
  logic [CutW-1:0]   cutoff_frac;
  logic [AddrW-1:0]  n, i;
  logic [16:0]       fc;
  logic [23:0]       mag;
  logic [23:0]       mag_next;
  logic signed [24:0] sinc;
  logic signed [24:0] win;
  logic signed [SumW-1:0] tap_sum;
  logic [6:0]        tap_counter;
  logic signed [49:0] prod;
  logic signed [24:0] raw;
  logic signed [CoefW-1:0] coef;
  logic              neg;

  wsfd_div_req_t dreq;
  wsfd_div_sts_t dsts;
  logic          c_start, c_busy;
  logic [31:0]   c_phase;
  logic signed [33:0] c_cos, c_sin;
  logic          ram_we;
  logic [RawW-1:0] ram_rd;
  logic signed [6:0] d2;
  logic          out_busy;
  logic          pend;

  wsfd_ram #(.Width(RawW), .Depth(MaxTaps)) u_ram (
    .clk(clk), .we(ram_we), .addr(i), .wdata(raw[RawW-1:0]), .rdata(ram_rd)
  );
  wsfd_cordic u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .phase(c_phase), .busy(c_busy),
    .cos_out(c_cos), .sin_out(c_sin)
  );
  wsfd_div u_div (.clk(clk), .rst(rst), .req(dreq), .sts(dsts));

  assign s_axis_tready = (state == ST_IDLE);
  assign d2 = 7'($signed({1'b0, i, 1'b0}) - $signed({2'b00, n}));

  // sinc phase magnitude |2i-N|*fc for the current tap
  assign mag_next = 24'({17'd0, d2[6] ? 7'(-d2) : d2} * fc);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= 6'd31;
      cutoff_frac  <= 17'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegOrder:  filter_order <= cfg_data[OrderW-1:0];
        RegCutoff: cutoff_frac  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_axis_tvalid && s_axis_tdata[0]) state_next = ST_SC_SETUP;
      ST_SC_SETUP:  state_next = (mag_next == '0) ? ST_WN_DIV : ST_SC_CORDIC;
      ST_SC_CORDIC: if (!pend && !c_busy) state_next = ST_SC_DIV;
      ST_SC_DIV:    if (!pend && !dsts.busy) state_next = ST_WN_DIV;
      ST_WN_DIV:    if (!pend && !dsts.busy) state_next = ST_WN_CORDIC;
      ST_WN_CORDIC: if (!pend && !c_busy) state_next = ST_MUL;
      ST_MUL:       state_next = ST_STORE;
      ST_STORE:     state_next = (i == n) ? ST_RD : ST_SC_SETUP;
      ST_RD:        state_next = ST_RDWAIT;
      ST_RDWAIT:    state_next = ST_CDIV;
      ST_CDIV:      if (!pend && !dsts.busy && !out_busy) state_next = ST_EMIT;
      ST_EMIT:      state_next = (i == n) ? ST_IDLE : ST_RD;
      default:      state_next = ST_IDLE;
    endcase
  end

  // unit launches and RAM write
  logic [31:0] rm_abs, sm_abs, s_abs;
  always_comb begin
    s_abs  = c_sin[33] ? 32'(-c_sin) : c_sin[31:0];
    rm_abs = ram_rd[23] ? 32'(-$signed(ram_rd)) : {8'd0, ram_rd};
    sm_abs = tap_sum[31] ? 32'(-tap_sum) : tap_sum;
    c_start = 1'b0;
    c_phase = '0;
    dreq    = '0;
    ram_we  = (state == ST_STORE);
    unique case (state)
      ST_SC_CORDIC: begin
        c_start = pend;
        c_phase = {mag[17:0], 14'd0};
      end
      ST_SC_DIV: begin
        dreq.start = pend;
        dreq.num   = {3'd0, s_abs, 29'd0};
        dreq.den   = 48'(PiQ20 * mag);
      end
      ST_WN_DIV: begin
        dreq.start = pend;
        dreq.num   = {26'd0, i, 32'd0};
        dreq.den   = {42'd0, n};
      end
      ST_WN_CORDIC: begin
        c_start = pend;
        c_phase = (n == '0) ? 32'd0 : dsts.quo[31:0];
      end
      ST_CDIV: begin
        dreq.start = pend && (tap_sum != 0);
        dreq.num   = {16'd0, rm_abs, 16'd0};
        dreq.den   = {16'd0, sm_abs};
      end
      default: ;
    endcase
  end

  // datapath registers
  logic signed [57:0] wprod;
  logic [63:0] qsat;
  always_comb begin
    wprod = W46Q22 * c_cos;
    qsat  = (dsts.quo > 64'd262144) ? 64'd262144 : dsts.quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      pend          <= 1'b0;
      tap_sum       <= '0;
      tap_counter   <= '0;
    end else begin
      state <= state_next;
      // output register: load on emit, clear once taken
      if (state == ST_EMIT) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // pend marks the first cycle of a wait state, when the unit launches
      pend <= (state_next != state);
      unique case (state)
        ST_IDLE: begin
          n  <= (filter_order > OrderW'(MaxTaps - 1)) ? AddrW'(MaxTaps - 1)
                                                      : filter_order[AddrW-1:0];
          fc <= (cutoff_frac > 17'd65536) ? 17'd65536 : cutoff_frac;
          i  <= '0;
          tap_sum <= (s_axis_tvalid && s_axis_tdata[0]) ? '0 : tap_sum;
        end
        ST_SC_SETUP: begin
          mag  <= mag_next;
          sinc <= OneQ22;
        end
        ST_SC_DIV: if (!pend && !dsts.busy) begin
          sinc <= c_sin[33] ? -$signed({1'b0, dsts.quo[23:0]})
                            : $signed({1'b0, dsts.quo[23:0]});
        end
        ST_WN_CORDIC: if (!pend && !c_busy) begin
          win <= 25'(W54Q22) - 25'(wprod >>> 30);
        end
        ST_MUL: prod <= sinc * win;
        ST_STORE: begin
          tap_sum <= tap_sum + SumW'(raw);
          if (i != n) i <= i + 1'b1;
          else        i <= '0;
        end
        ST_CDIV: if (!pend && !dsts.busy && !out_busy) begin
          neg <= ram_rd[23] != tap_sum[31];
        end
        ST_EMIT: begin
          m_axis_tdata  <= {8'd0, coef, i};
          m_axis_tlast  <= (i == n);
          if (i == n) tap_counter <= 7'(n) + 7'd1;
          else        i <= i + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_busy = m_axis_tvalid && !m_axis_tready;

  // raw tap saturation
  logic signed [49:0] pshift;
  always_comb begin
    pshift = prod >>> 22;
    if (pshift > 50'(RawMax))      raw = RawMax;
    else if (pshift < 50'(RawMin)) raw = RawMin;
    else                           raw = pshift[24:0];
  end

  // coefficient sign and saturation
  logic signed [19:0] cv;
  always_comb begin
    cv = neg ? -$signed({1'b0, qsat[18:0]}) : $signed({1'b0, qsat[18:0]});
    if (tap_sum == 0)             coef = '0;
    else if (cv > 20'sd131071)    coef = 18'sd131071;
    else if (cv < -20'sd131072)   coef = -18'sd131072;
    else                          coef = cv[CoefW-1:0];
  end

  logic unused;
  assign unused = ^{tap_counter, s_axis_tdata[7:1], dsts.quo[63:32]};
endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for the windowed-sinc Hamming FIR designer core: directed table, then random sets.
`timescale 1ns / 1ps
module tb;
  import wsfd_pkg::*;

  typedef struct {
    logic [5:0]         idx;
    logic signed [17:0] coef;
    logic               last;
  } tap_t;

  typedef struct {
    bit                 wr;      // write order and cutoff before this request
    logic [5:0]         order;
    logic [16:0]        cut;
    bit                 start;
    bit                 typed;   // single tap with a known coefficient
    logic signed [17:0] coef;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [5:0] tap_index, [23:6] coefficient
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = RegOrder;
  logic [16:0] cfg_data = '0;

  windowed_sinc_fir_designer_core u_top (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  // predictor state
  logic [5:0]  cur_order = 6'd31;
  logic [16:0] cur_cut   = 17'd32768;
  tap_t        pending_taps[$];
  int          errors = 0;
  int          idle_mode = 0;     // 0 none, 1 sender, 2 receiver, 3 both
  int          hold_reqs = 0;
  int          hold_done = 0;

  longint atan_tbl[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                           21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                           333772, 166886, 83443, 41722, 20861};

  function automatic void rotate(input logic [31:0] phase, output longint c,
                                 output longint s);
    logic [31:0] p;
    logic [31:0] t;
    bit     flip;
    longint x, y, z, xs, ys;
    p = phase;
    t = p + 32'h4000_0000;
    flip = (t >= 32'h8000_0000);
    if (flip) p = p + 32'h8000_0000;
    z = longint'(int'(p));
    x = 652032874;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tbl[k];
      end else begin
        x += ys; y -= xs; z += atan_tbl[k];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint sinc_val(input longint fc, input longint d2);
    longint unsigned mag, num, den, q, ph;
    longint c, s;
    mag = (d2 < 0 ? -d2 : d2) * fc;
    if (mag == 0) return 4194304;
    ph = mag << 14;
    rotate(ph[31:0], c, s);
    num = longint'(s < 0 ? -s : s) << 29;
    den = 64'd3294198 * mag;
    q = num / den;
    return s < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint hamming_val(input longint i, input longint n);
    longint unsigned ph;
    longint c, s;
    ph = 0;
    if (n != 0) ph = (longint'(i) << 32) / n;
    rotate(ph[31:0], c, s);
    return 2264924 - ((longint'(1929380) * c) >>> 30);
  endfunction

  // design one coefficient set from the current settings
  function automatic void design_taps();
    longint n, fc, r, acc, sum, rm, sm, q, v;
    longint raws[64];
    tap_t   t;
    n = cur_order;
    fc = (cur_cut > 17'd65536) ? 65536 : cur_cut;
    acc = 0;
    for (int i = 0; i <= n; i++) begin
      r = (sinc_val(fc, 2 * i - n) * hamming_val(i, n)) >>> 22;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      raws[i] = r;
      acc += r;
    end
    sum = longint'(int'(acc));
    for (int i = 0; i <= n; i++) begin
      v = 0;
      if (sum != 0) begin
        rm = (raws[i] < 0 ? -raws[i] : raws[i]) << 16;
        sm = sum < 0 ? -sum : sum;
        q = rm / sm;
        if (q > 262144) q = 262144;
        v = ((raws[i] < 0) != (sum < 0)) ? -q : q;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
      end
      t.idx = i[5:0];
      t.coef = v[17:0];
      t.last = (i == n);
      pending_taps.push_back(t);
    end
  endfunction

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_reqs != hold_done) begin
      m_axis_tready <= 1'b0;
      repeat (4000) @(posedge clk);
      hold_done = hold_done + 1;
    end else if (idle_mode == 2) begin
      m_axis_tready <= ($urandom_range(99) >= 62);
    end else if (idle_mode == 3) begin
      m_axis_tready <= ($urandom_range(99) >= 35);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    tap_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_taps.size() == 0) begin
        $display("%0t: unexpected tap idx=%0d coef=%0d last=%0b", $time,
                 m_axis_tdata[5:0], $signed(m_axis_tdata[23:6]), m_axis_tlast);
        errors++;
      end else begin
        e = pending_taps.pop_front();
        if (m_axis_tdata[5:0] !== e.idx || m_axis_tdata[23:6] !== e.coef ||
            m_axis_tlast !== e.last) begin
          $display("%0t: tap mismatch exp idx=%0d coef=%0d last=%0b got idx=%0d coef=%0d last=%0b",
                   $time, e.idx, e.coef, e.last, m_axis_tdata[5:0],
                   $signed(m_axis_tdata[23:6]), m_axis_tlast);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegOrder) cur_order = val[5:0];
    else cur_cut = val;
  endtask

  task automatic set_filter(input logic [5:0] order, input logic [16:0] cut);
    wait_drained();
    write_reg(RegOrder, {11'd0, order});
    write_reg(RegCutoff, cut);
  endtask

  // offer one request; typed rows queue a known single tap instead of the predictor
  task automatic send_request(input bit start, input bit typed,
                              input logic signed [17:0] coef);
    tap_t t;
    int   gap_pct;
    gap_pct = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 35 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, start};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (start && typed) begin
      t.idx = 6'd0; t.coef = coef; t.last = 1'b1;
      pending_taps.push_back(t);
    end else if (start) begin
      design_taps();
    end
  endtask

  row_t dir_rows[13] = '{
    '{0, 6'd0,  17'd0,      1, 0, 18'sd0},      // reset settings
    '{0, 6'd0,  17'd0,      0, 0, 18'sd0},      // no request
    '{1, 6'd0,  17'd32768,  1, 1, 18'sd65536},  // order zero
    '{1, 6'd0,  17'd0,      1, 1, 18'sd65536},  // order zero, zero cutoff
    '{1, 6'd1,  17'd0,      1, 0, 18'sd0},
    '{1, 6'd1,  17'd65536,  1, 0, 18'sd0},
    '{1, 6'd63, 17'd131071, 1, 0, 18'sd0},      // cutoff above one, max order
    '{1, 6'd63, 17'd65536,  1, 0, 18'sd0},
    '{1, 6'd2,  17'd1,      1, 0, 18'sd0},
    '{1, 6'd5,  17'd100000, 1, 0, 18'sd0},
    '{1, 6'd4,  17'd65535,  1, 0, 18'sd0},
    '{1, 6'd7,  17'd40000,  0, 0, 18'sd0},
    '{1, 6'd3,  17'd20000,  1, 0, 18'sd0}
  };

  initial begin
    logic [5:0]  order;
    logic [16:0] cut;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].wr) set_filter(dir_rows[r].order, dir_rows[r].cut);
      send_request(dir_rows[r].start, dir_rows[r].typed, dir_rows[r].coef);
    end

    // random sets: settings change between phases
    for (int ph = 0; ph < 20; ph++) begin
      if (ph == 7 || ph == 15) order = 6'd63;
      else if ($urandom_range(9) == 0) order = 6'($urandom_range(63));
      else order = 6'($urandom_range(10));
      case ($urandom_range(5))
        0: cut = 17'($urandom_range(131071));
        1: cut = 17'd65536;
        2: cut = 17'($urandom_range(2000));
        default: cut = 17'($urandom_range(65536));
      endcase
      set_filter(order, cut);
      idle_mode = ph % 4;
      if (ph == 5 || ph == 13) hold_reqs = hold_reqs + 1;
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(9) == 0) send_request(1'b0, 1'b0, 18'sd0);
        send_request(1'b1, 1'b0, 18'sd0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #300ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
design/wsfd_pkg.sv
design/wsfd_ram.sv
design/wsfd_cordic.sv
design/wsfd_div.sv
design/windowed_sinc_fir_designer_core.sv
tb/tb.sv
